@@ design/i2c_master_transfer_sequencer_defines.svh @@
// Assertion macros shared by the I2C transfer sequencer RTL.
// No dependencies; simulation builds get live checks, synthesis gets empty bodies.
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on the rising clock edge.
`define SEQ_ASSERT_NOW(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error("sequencer check failed");
// Next-cycle implication.
`define SEQ_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error("sequencer check failed");
`else
`define SEQ_ASSERT_NOW(label, clk, rst_n, cond, expr)
`define SEQ_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif

`endif

@@ design/i2cseq_pkg.sv @@
// Types and constants for the I2C master transfer sequencer.
// No dependencies; used by i2c_master_transfer_sequencer.
`default_nettype none

package i2cseq_pkg;

	// Operation codes carried in the op field.
	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_READ   = 2'd1;
	localparam logic [1:0] OP_STATUS = 2'd2;

	// Bit positions inside status_flags.
	localparam int unsigned FL_SB   = 0;
	localparam int unsigned FL_ADDR = 1;
	localparam int unsigned FL_BTF  = 2;
	localparam int unsigned FL_TXE  = 3;
	localparam int unsigned FL_RXNE = 4;

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_WAIT_SB   = 4'd1,
		PH_WAIT_ADDR = 4'd2,
		PH_W_DATA    = 4'd3,
		PH_W_TXE     = 4'd4,
		PH_W_BTF     = 4'd5,
		PH_R_ONE     = 4'd6,
		PH_R_MANY    = 4'd7
	} phase_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [6:0]  slave_address;
		logic [15:0] transfer_length;
		logic [4:0]  status_flags;
		logic [7:0]  read_data;
		logic [7:0]  tx_byte;
	} in_word_t;

	typedef struct packed {
		logic       gen_start;
		logic       gen_stop;
		logic       ack_write;
		logic       ack_level;
		logic       clear_addr;
		logic       dr_write;
		logic [7:0] dr_value;
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic       done_res;
		logic       busy_res;
	} out_word_t;

endpackage

`default_nettype wire

@@ design/i2c_master_transfer_sequencer.sv @@
// Path: a word accepted into stage one has its result word computed by the phase
// machine and registered into the result register when it leaves stage one.
// Throughput: one word per cycle while out_ready is high; while a result waits on
// out_ready, one further word is taken into stage one and then in_ready drops.
// Reset (arst_n low, asynchronous): phase idle, counters cleared, both pipeline
// registers empty, acknowledge re-enable default set to one.
//
// Top level of the I2C master transfer sequencer; depends on i2cseq_pkg and
// i2c_master_transfer_sequencer_defines.svh.
`default_nettype none
`include "i2c_master_transfer_sequencer_defines.svh"

module i2c_master_transfer_sequencer
	import i2cseq_pkg::*;
#(
	parameter int unsigned LEN_WIDTH = 16
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_word_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_word_t      out_data,
	input  wire logic      cfg_we,
	input  wire logic      cfg_wdata
);

	// The sequencer is a two-register pipeline. Stage one simply captures the
	// incoming word. Between stage one and the result register sits the phase
	// machine: it looks at the captured word and the current phase, produces
	// the result word and the next phase in one pass of short logic, and both
	// are committed at the same edge. Because the transfer state only moves
	// when a word leaves stage one, words are processed strictly in order.

	// Stage one: captured input word.
	logic     valid_s1;
	in_word_t word_s1;

	// Result register.
	logic      out_valid_q;
	out_word_t out_word_q;

	// Transfer state.
	phase_t               phase_q;
	logic [LEN_WIDTH-1:0] bytes_left_q;
	logic                 read_dir_q;
	logic [6:0]           target_addr_q;
	logic                 ack_default_q;

	// Next-state values from the phase machine.
	phase_t               phase_d;
	logic [LEN_WIDTH-1:0] bytes_left_d;
	logic                 read_dir_d;
	logic [6:0]           target_addr_d;
	out_word_t            result_d;

	logic advance;
	logic [LEN_WIDTH+15:0] len_ext;
	logic [LEN_WIDTH-1:0]  len_begin;
	logic [LEN_WIDTH-1:0]  bytes_dec;
	logic                  is_status;
	logic                  flag_sb;
	logic                  flag_addr;
	logic                  flag_btf;
	logic                  flag_txe;
	logic                  flag_rxne;

	// A word leaves stage one whenever the result register is empty or is
	// being emptied this cycle; stage one refills in the same cycle.
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_word_q;

	// The length is cut to, or widened to, the counter width.
	assign len_ext   = {{LEN_WIDTH{1'b0}}, word_s1.transfer_length};
	assign len_begin = len_ext[LEN_WIDTH-1:0];
	assign bytes_dec = bytes_left_q - LEN_WIDTH'(1);

	assign is_status = (word_s1.op == OP_STATUS);
	assign flag_sb   = word_s1.status_flags[FL_SB];
	assign flag_addr = word_s1.status_flags[FL_ADDR];
	assign flag_btf  = word_s1.status_flags[FL_BTF];
	assign flag_txe  = word_s1.status_flags[FL_TXE];
	assign flag_rxne = word_s1.status_flags[FL_RXNE];

	// Next-state logic. Begin words are only honoured in idle; status words
	// are only honoured outside idle; anything else leaves the state alone.
	always_comb begin
		phase_d       = phase_q;
		bytes_left_d  = bytes_left_q;
		read_dir_d    = read_dir_q;
		target_addr_d = target_addr_q;
		if (phase_q == PH_IDLE) begin
			if (word_s1.op == OP_WRITE || word_s1.op == OP_READ) begin
				target_addr_d = word_s1.slave_address;
				read_dir_d    = (word_s1.op == OP_READ);
				bytes_left_d  = len_begin;
				phase_d       = PH_WAIT_SB;
			end
		end else if (is_status) begin
			case (phase_q)
				PH_WAIT_SB: begin
					if (flag_sb) begin
						phase_d = PH_WAIT_ADDR;
					end
				end
				PH_WAIT_ADDR: begin
					if (flag_addr) begin
						if (!read_dir_q) begin
							phase_d = (bytes_left_q != '0) ? PH_W_DATA : PH_W_TXE;
						end else if (bytes_left_q == LEN_WIDTH'(1)) begin
							phase_d = PH_R_ONE;
						end else if (bytes_left_q != '0) begin
							phase_d = PH_R_MANY;
						end else begin
							phase_d = PH_IDLE;
						end
					end
				end
				PH_W_DATA: begin
					if (flag_txe) begin
						bytes_left_d = bytes_dec;
						if (bytes_dec == '0) begin
							phase_d = PH_W_TXE;
						end
					end
				end
				PH_W_TXE: begin
					if (flag_txe) begin
						phase_d = PH_W_BTF;
					end
				end
				PH_W_BTF: begin
					if (flag_btf) begin
						phase_d = PH_IDLE;
					end
				end
				PH_R_ONE: begin
					if (flag_rxne) begin
						bytes_left_d = '0;
						phase_d      = PH_IDLE;
					end
				end
				PH_R_MANY: begin
					if (flag_rxne) begin
						bytes_left_d = bytes_dec;
						if (bytes_dec == '0) begin
							phase_d = PH_IDLE;
						end
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	// Output logic. Everything defaults to zero; a phase whose flag has not
	// arrived yet only reports that the transfer is still busy.
	always_comb begin
		result_d = '0;
		if (phase_q == PH_IDLE) begin
			if (word_s1.op == OP_WRITE || word_s1.op == OP_READ) begin
				result_d.gen_start = 1'b1;
			end
		end else if (is_status) begin
			case (phase_q)
				PH_WAIT_SB: begin
					if (flag_sb) begin
						// Address byte: seven address bits then the direction bit.
						result_d.dr_write = 1'b1;
						result_d.dr_value = {target_addr_q, read_dir_q};
					end
				end
				PH_WAIT_ADDR: begin
					if (flag_addr) begin
						result_d.clear_addr = 1'b1;
						if (read_dir_q) begin
							if (bytes_left_q == LEN_WIDTH'(1)) begin
								// Single byte: NACK must be armed before the flag clears.
								result_d.ack_write = 1'b1;
								result_d.ack_level = 1'b0;
							end else if (bytes_left_q == '0) begin
								// Empty read finishes at once.
								result_d.gen_stop  = 1'b1;
								result_d.ack_write = ack_default_q;
								result_d.ack_level = ack_default_q;
								result_d.done_res  = 1'b1;
							end
						end
					end
				end
				PH_W_DATA: begin
					if (flag_txe) begin
						result_d.dr_write = 1'b1;
						result_d.dr_value = word_s1.tx_byte;
					end
				end
				PH_W_BTF: begin
					if (flag_btf) begin
						result_d.gen_stop = 1'b1;
						result_d.done_res = 1'b1;
					end
				end
				PH_R_ONE: begin
					if (flag_rxne) begin
						result_d.gen_stop  = 1'b1;
						result_d.rx_valid  = 1'b1;
						result_d.rx_byte   = word_s1.read_data;
						result_d.ack_write = ack_default_q;
						result_d.ack_level = ack_default_q;
						result_d.done_res  = 1'b1;
					end
				end
				PH_R_MANY: begin
					if (flag_rxne) begin
						result_d.rx_valid = 1'b1;
						result_d.rx_byte  = word_s1.read_data;
						if (bytes_left_q == LEN_WIDTH'(2)) begin
							// Two bytes left: NACK the last one and queue STOP.
							result_d.ack_write = 1'b1;
							result_d.ack_level = 1'b0;
							result_d.gen_stop  = 1'b1;
						end
						if (bytes_dec == '0) begin
							result_d.ack_write = ack_default_q;
							result_d.ack_level = ack_default_q;
							result_d.done_res  = 1'b1;
						end
					end
				end
				default: begin
					result_d = '0;
				end
			endcase
		end
		result_d.busy_res = (phase_d != PH_IDLE);
	end

	// Stage one capture.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= in_data;
		end
	end

	// Result register; a word waits here while out_ready is low.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_word_q <= result_d;
		end
	end

	// Transfer state is committed together with the result word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			bytes_left_q  <= '0;
			read_dir_q    <= 1'b0;
			target_addr_q <= '0;
		end else if (advance) begin
			phase_q       <= phase_d;
			bytes_left_q  <= bytes_left_d;
			read_dir_q    <= read_dir_d;
			target_addr_q <= target_addr_d;
		end
	end

	// Acknowledge re-enable default; it is meant to be written only while no
	// word is in flight, and takes effect on the next word processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_default_q <= 1'b1;
		end else if (cfg_we) begin
			ack_default_q <= cfg_wdata;
		end
	end

	// A finished transfer never reports itself busy.
	`SEQ_ASSERT_NOW(a_done_not_busy, clk, arst_n, out_valid_q && out_word_q.done_res, !out_word_q.busy_res)
	// START is requested on its own, never with a data write or STOP.
	`SEQ_ASSERT_NOW(a_start_alone, clk, arst_n, out_valid_q && out_word_q.gen_start, !out_word_q.dr_write && !out_word_q.gen_stop && out_word_q.busy_res)
	// Every transfer leaves the byte counter empty when it returns to idle.
	`SEQ_ASSERT_NOW(a_idle_count_zero, clk, arst_n, phase_q == PH_IDLE, bytes_left_q == '0)
	// An accepted word is always held in stage one on the next cycle.
	`SEQ_ASSERT_NEXT(a_capture, clk, arst_n, in_valid && in_ready, valid_s1)

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the I2C master transfer sequencer (polled write and read).
// A local model predicts every result word; the block comes from i2c_master_transfer_sequencer
// and the types from i2cseq_pkg.
module testbench;
	import i2cseq_pkg::*;

	localparam int unsigned LEN_W = 16;

	// The op field has one code that the block does not use; it must be ignored.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Single-bit masks for the status snapshot, built from the package bit positions.
	localparam logic [4:0] F_SB   = 5'd1 << FL_SB;
	localparam logic [4:0] F_ADDR = 5'd1 << FL_ADDR;
	localparam logic [4:0] F_BTF  = 5'd1 << FL_BTF;
	localparam logic [4:0] F_TXE  = 5'd1 << FL_TXE;
	localparam logic [4:0] F_RXNE = 5'd1 << FL_RXNE;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_word_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_word_t out_data;
	logic      cfg_we = 1'b0;
	logic      cfg_wdata = 1'b0;

	i2c_master_transfer_sequencer #(
		.LEN_WIDTH(LEN_W)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Period of two time units: one high, one low.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Our own copy of the sequencer state and of the acknowledge re-enable register.
	phase_t           m_phase = PH_IDLE;
	logic [LEN_W-1:0] m_left = '0;
	logic             m_read = 1'b0;
	logic [6:0]       m_target = '0;
	logic             m_ack_default = 1'b1;

	// Engine commands still owed by the block, oldest first.
	out_word_t awaited_commands[$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned n_words_sent = 0;
	int unsigned n_checked = 0;
	int unsigned n_finished = 0;
	int unsigned n_errors = 0;

	// Advances the local copy of the sequencer by one input word and returns the
	// command word that the block must produce for it. Every word, ignored or not,
	// yields exactly one result word.
	function automatic out_word_t sequence_step(in_word_t w);
		out_word_t o;
		o = '0;
		if (m_phase == PH_IDLE) begin
			// Only a begin word leaves idle; snapshots and the unused op are dropped.
			if (w.op == OP_WRITE || w.op == OP_READ) begin
				m_target = w.slave_address;
				m_read = (w.op == OP_READ);
				m_left = w.transfer_length[LEN_W-1:0];
				o.gen_start = 1'b1;
				m_phase = PH_WAIT_SB;
			end
		end else if (w.op == OP_STATUS) begin
			// A begin word while busy is ignored and the transfer carries on.
			case (m_phase)
				PH_WAIT_SB: begin
					if (w.status_flags[FL_SB]) begin
						o.dr_write = 1'b1;
						o.dr_value = {m_target, m_read};
						m_phase = PH_WAIT_ADDR;
					end
				end
				PH_WAIT_ADDR: begin
					if (w.status_flags[FL_ADDR]) begin
						o.clear_addr = 1'b1;
						if (!m_read) begin
							// A zero-length write skips the payload and goes straight to the drain waits.
							m_phase = (m_left != '0) ? PH_W_DATA : PH_W_TXE;
						end else if (m_left == LEN_W'(1)) begin
							// A single-byte read must drop ACK before the address flag is cleared.
							o.ack_write = 1'b1;
							o.ack_level = 1'b0;
							m_phase = PH_R_ONE;
						end else if (m_left != '0) begin
							m_phase = PH_R_MANY;
						end else begin
							// A zero-length read stops at once and returns no byte.
							o.gen_stop = 1'b1;
							o.ack_write = m_ack_default;
							o.ack_level = m_ack_default;
							o.done_res = 1'b1;
							m_phase = PH_IDLE;
						end
					end
				end
				PH_W_DATA: begin
					if (w.status_flags[FL_TXE]) begin
						o.dr_write = 1'b1;
						o.dr_value = w.tx_byte;
						m_left = m_left - 1'b1;
						if (m_left == '0)
							m_phase = PH_W_TXE;
					end
				end
				PH_W_TXE: begin
					if (w.status_flags[FL_TXE])
						m_phase = PH_W_BTF;
				end
				PH_W_BTF: begin
					if (w.status_flags[FL_BTF]) begin
						o.gen_stop = 1'b1;
						o.done_res = 1'b1;
						m_phase = PH_IDLE;
					end
				end
				PH_R_ONE: begin
					if (w.status_flags[FL_RXNE]) begin
						o.gen_stop = 1'b1;
						o.rx_valid = 1'b1;
						o.rx_byte = w.read_data;
						o.ack_write = m_ack_default;
						o.ack_level = m_ack_default;
						o.done_res = 1'b1;
						m_left = '0;
						m_phase = PH_IDLE;
					end
				end
				PH_R_MANY: begin
					if (w.status_flags[FL_RXNE]) begin
						// With two bytes left, ACK is dropped and STOP requested on this byte.
						if (m_left == LEN_W'(2)) begin
							o.ack_write = 1'b1;
							o.ack_level = 1'b0;
							o.gen_stop = 1'b1;
						end
						o.rx_valid = 1'b1;
						o.rx_byte = w.read_data;
						m_left = m_left - 1'b1;
						if (m_left == '0) begin
							o.ack_write = m_ack_default;
							o.ack_level = m_ack_default;
							o.done_res = 1'b1;
							m_phase = PH_IDLE;
						end
					end
				end
				default: m_phase = PH_IDLE;
			endcase
		end
		o.busy_res = (m_phase != PH_IDLE);
		return o;
	endfunction

	function automatic in_word_t random_word(logic [1:0] op);
		in_word_t w;
		w.op = op;
		w.slave_address = 7'($urandom_range(127));
		w.transfer_length = 16'($urandom_range(65535));
		w.status_flags = 5'($urandom_range(31));
		w.read_data = 8'($urandom_range(255));
		w.tx_byte = 8'($urandom_range(255));
		return w;
	endfunction

	// Offers one word to the block, with random idle cycles beforehand when the
	// phase asks for them. Valid is left high after the handshake so that
	// back-to-back words follow without a gap; the prediction is taken at acceptance.
	task automatic send_word(in_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do
			@(posedge clk);
		while (!in_ready);
		awaited_commands.push_back(sequence_step(w));
		n_words_sent++;
	endtask

	task automatic start_transfer(logic [1:0] op, logic [6:0] addr, logic [15:0] len);
		in_word_t w;
		w = random_word(op);
		w.slave_address = addr;
		w.transfer_length = len;
		send_word(w);
	endtask

	task automatic snapshot(logic [4:0] flags, logic [7:0] data);
		in_word_t w;
		w = random_word(OP_STATUS);
		w.status_flags = flags;
		w.read_data = data;
		w.tx_byte = data;
		send_word(w);
	endtask

	// Holds the sender back until every owed word has come out, then lets a
	// few more cycles pass so that a stray extra word would still be caught.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (awaited_commands.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// The register is only written with nothing in flight.
	task automatic set_ack_default(logic value);
		wait_for_results();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		m_ack_default = value;
	endtask

	task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			n_errors++;
		end
	endtask

	// Result side: every accepted word is matched against the oldest owed word,
	// and out_ready is redrawn each cycle from the current stall rate.
	always @(posedge clk) begin : result_check
		out_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_commands.size() == 0) begin
				$error("result word with nothing owed: %h", out_data);
				n_errors++;
			end else begin
				want = awaited_commands.pop_front();
				compare_field("gen_start", 8'(want.gen_start), 8'(out_data.gen_start));
				compare_field("gen_stop", 8'(want.gen_stop), 8'(out_data.gen_stop));
				compare_field("ack_write", 8'(want.ack_write), 8'(out_data.ack_write));
				compare_field("ack_level", 8'(want.ack_level), 8'(out_data.ack_level));
				compare_field("clear_addr", 8'(want.clear_addr), 8'(out_data.clear_addr));
				compare_field("dr_write", 8'(want.dr_write), 8'(out_data.dr_write));
				compare_field("dr_value", want.dr_value, out_data.dr_value);
				compare_field("rx_valid", 8'(want.rx_valid), 8'(out_data.rx_valid));
				compare_field("rx_byte", want.rx_byte, out_data.rx_byte);
				compare_field("done_res", 8'(want.done_res), 8'(out_data.done_res));
				compare_field("busy_res", 8'(want.busy_res), 8'(out_data.busy_res));
				n_checked++;
				if (want.done_res)
					n_finished++;
			end
		end
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Hand-picked words: field extremes, every op, ignored words in both states,
	// a flag that is not yet set, and the zero-length and short-read corners.
	task automatic test_directed_cases();
		set_ack_default(1'b1);
		snapshot(5'h1F, 8'hFF);
		send_word(random_word(OP_UNUSED));
		// Two-byte write to the top address, with ignored words mixed in.
		start_transfer(OP_WRITE, 7'h7F, 16'd2);
		snapshot(5'h00, 8'h00);
		snapshot(F_SB, 8'h00);
		snapshot(F_ADDR, 8'h00);
		start_transfer(OP_READ, 7'h00, 16'hFFFF);
		snapshot(F_TXE, 8'hFF);
		send_word(random_word(OP_UNUSED));
		snapshot(F_TXE, 8'h00);
		snapshot(F_TXE, 8'h00);
		snapshot(F_BTF, 8'h00);
		// Zero-length write.
		start_transfer(OP_WRITE, 7'h00, 16'd0);
		snapshot(F_SB, 8'h00);
		snapshot(F_ADDR, 8'h00);
		snapshot(F_TXE, 8'h00);
		snapshot(F_BTF, 8'h00);
		// Zero-length read, then a one-byte read.
		start_transfer(OP_READ, 7'h55, 16'd0);
		snapshot(F_SB, 8'h00);
		snapshot(F_ADDR, 8'h00);
		start_transfer(OP_READ, 7'h2A, 16'd1);
		snapshot(F_SB, 8'h00);
		snapshot(F_ADDR, 8'h00);
		snapshot(F_RXNE, 8'hFF);
		// Three-byte read: STOP goes out on the byte taken with two remaining.
		start_transfer(OP_READ, 7'h01, 16'd3);
		snapshot(F_SB, 8'h00);
		snapshot(F_ADDR, 8'h00);
		snapshot(F_RXNE, 8'h00);
		snapshot(F_RXNE, 8'hA5);
		snapshot(5'h1F, 8'h5A);
	endtask

	// With the re-enable default cleared, reads must leave ACK alone at the end.
	task automatic test_ack_restore_off();
		set_ack_default(1'b0);
		start_transfer(OP_READ, 7'h11, 16'd0);
		snapshot(F_SB, 8'h00);
		snapshot(F_ADDR, 8'h00);
		start_transfer(OP_READ, 7'h22, 16'd1);
		snapshot(F_SB, 8'h00);
		snapshot(F_ADDR, 8'h00);
		snapshot(F_RXNE, 8'h3C);
		start_transfer(OP_READ, 7'h33, 16'd2);
		snapshot(F_SB, 8'h00);
		snapshot(F_ADDR, 8'h00);
		snapshot(F_RXNE, 8'hC3);
		snapshot(F_RXNE, 8'h7E);
	endtask

	// Mostly complete transfers with random content. While a transfer runs, most
	// snapshots carry the flag that the current phase waits for, some carry
	// arbitrary flags, and a few are arbitrary words of any op.
	task automatic test_random_traffic(int unsigned count, int unsigned idle_pct,
			int unsigned stall_pct, logic ack_default);
		int unsigned useful;
		int unsigned roll;
		in_word_t w;
		logic [4:0] needed;
		set_ack_default(ack_default);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		useful = 0;
		while (useful < count) begin
			if ($urandom_range(9) == 0) begin
				// Words that idle simply drops.
				send_word(random_word(($urandom_range(1) != 0) ? OP_STATUS : OP_UNUSED));
			end else begin
				w = random_word(($urandom_range(1) != 0) ? OP_READ : OP_WRITE);
				if ($urandom_range(15) == 0)
					w.transfer_length = 16'($urandom_range(40, 7));
				else
					w.transfer_length = 16'($urandom_range(6));
				send_word(w);
				useful++;
				while (m_phase != PH_IDLE) begin
					case (m_phase)
						PH_WAIT_SB:   needed = F_SB;
						PH_WAIT_ADDR: needed = F_ADDR;
						PH_W_DATA:    needed = F_TXE;
						PH_W_TXE:     needed = F_TXE;
						PH_W_BTF:     needed = F_BTF;
						default:      needed = F_RXNE;
					endcase
					roll = $urandom_range(99);
					if (roll < 8) begin
						send_word(random_word(2'($urandom_range(3))));
					end else begin
						w = random_word(OP_STATUS);
						if (roll < 75)
							w.status_flags = w.status_flags | needed;
						send_word(w);
						useful++;
					end
				end
			end
		end
	endtask

	// One long read whose length uses the counter's upper byte, so that the
	// count runs down through a borrow into it; no idling, to keep the run short.
	task automatic test_longest_read();
		set_ack_default(1'b1);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		start_transfer(OP_READ, 7'h7F, 16'd261);
		snapshot(F_SB, 8'h00);
		snapshot(F_ADDR, 8'h00);
		repeat (261)
			snapshot(F_RXNE | 5'($urandom_range(31)), 8'($urandom_range(255)));
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_ack_restore_off();
		test_random_traffic(300, 0, 0, 1'b1);
		test_random_traffic(300, 78, 0, 1'b0);
		test_random_traffic(300, 0, 78, 1'b1);
		test_random_traffic(300, 13, 13, 1'($urandom_range(1)));
		test_longest_read();
		wait_for_results();
		$display("Checked %0d result words from %0d input words; %0d transfers finished.",
			n_checked, n_words_sent, n_finished);
		$display("Covered short and long writes and reads, ignored words, stalls on both sides, ACK re-enable on and off.");
		if (n_errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Guard against a hung handshake: the timeout lies far beyond a correct run.
	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
